[rtl/core/ethernet_ip_l4_header_parser_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the Ethernet / IP / L4 header parser
// Clocked assertion wrappers used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef ETHERNET_IP_L4_HEADER_PARSER_MACROS_SVH
`define ETHERNET_IP_L4_HEADER_PARSER_MACROS_SVH

// Check a property on every rising clock edge outside of reset.
`define EIPL4_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define EIPL4_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

[rtl/core/eipl4_pkg.sv]
// ----------------------------------------------------------------------------
// eipl4_pkg
// Constants, codes and helpers for the Ethernet / IP / L4 header parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package eipl4_pkg;

   typedef logic [1:0] kind_type;
   typedef logic [1:0] mark_type;

   localparam kind_type KIND_IPV4  = 2'd0;
   localparam kind_type KIND_IPV6  = 2'd1;
   localparam kind_type KIND_OTHER = 2'd2;

   localparam mark_type MARK_NONE = 2'd0;
   localparam mark_type MARK_SYN  = 2'd1;
   localparam mark_type MARK_FIN  = 2'd2;

   localparam logic [15:0] ETH_IPV4  = 16'h0800;
   localparam logic [15:0] ETH_IPV6  = 16'h86DD;
   localparam logic [3:0]  VER_IPV4  = 4'd4;
   localparam logic [3:0]  VER_IPV6  = 4'd6;
   localparam logic [7:0]  PROTO_TCP = 8'd6;
   localparam logic [7:0]  PROTO_UDP = 8'd17;
   localparam logic [7:0]  TCP_SYN   = 8'h02;
   localparam logic [7:0]  TCP_FIN   = 8'h01;

   localparam int POS_W = 7;
   localparam logic [POS_W-1:0] POS_MAX        = 7'd127;
   localparam logic [POS_W-1:0] ETH_HDR_LEN    = 7'd14;
   localparam logic [POS_W-1:0] IPV6_L4_START  = 7'd54;
   localparam logic [POS_W-1:0] POS_ETYPE_HI   = 7'd12;
   localparam logic [POS_W-1:0] POS_ETYPE_LO   = 7'd13;
   localparam logic [POS_W-1:0] POS_IP_FIRST   = 7'd14;
   localparam logic [POS_W-1:0] POS_V4_PROTO   = 7'd23;
   localparam logic [POS_W-1:0] POS_V6_NEXT    = 7'd20;
   localparam int V4_SRC_END   = 29;
   localparam int V4_DST_END   = 33;
   localparam int V6_SRC_END   = 37;
   localparam int V6_DST_END   = 53;
   localparam int DST_MAC_END  = 5;
   localparam int SRC_MAC_END  = 11;
   localparam logic [POS_W:0] FLAGS_OFFSET = 8'd13;

   localparam int RSP_DATA_W = 416;
   localparam int RSP_USER_W = 2;

   function automatic kind_type kind_of(input logic [15:0] etype, input logic [7:0] first);
      kind_type k;
      k = KIND_OTHER;
      if (etype == ETH_IPV4 && first[7:4] == VER_IPV4) begin
         k = KIND_IPV4;
      end else if (etype == ETH_IPV6 && first[7:4] == VER_IPV6) begin
         k = KIND_IPV6;
      end
      return k;
   endfunction

endpackage

[rtl/core/ethernet_ip_l4_header_parser.sv]
// ----------------------------------------------------------------------------
// ethernet_ip_l4_header_parser
// Captures Ethernet, IPv4/IPv6 and TCP/UDP header fields by byte position
// and emits one header summary per frame.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one frame byte per item, starting at destination MAC
//   byte 0; req_tlast marks the final byte of a frame. rsp_* carries one
//   header summary per frame, issued for the item marked last.
//   Throughput: one byte per cycle while req_tready is high, frames back to back.
//   Latency: the summary is valid the cycle after the last byte is taken;
//   capture logic sits between the position/capture registers and a
//   single result register.
//   Stall: a summary waiting on rsp_tready holds; req_tready drops only
//   while that register is full and not being taken, otherwise bytes of
//   the next frame keep flowing.
//   Reset: synchronous, active high; clears the byte position, all capture
//   registers and the result valid. Capture state also clears after every
//   frame. Bytes past position 127 capture nothing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ethernet_ip_l4_header_parser_macros.svh"

module ethernet_ip_l4_header_parser (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [7:0]                        req_tdata,  // [7:0] packet_byte
   input  logic                              req_tlast,  // last_byte
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [47:0] dst_mac, [95:48] src_mac, [111:96] ether_type,
   // [175:112] ip_src_high, [239:176] ip_src_low, [303:240] ip_dst_high,
   // [367:304] ip_dst_low, [375:368] proto_number, [391:376] src_port,
   // [407:392] dst_port, [409:408] tcp_mark, [415:410] zero
   output logic [eipl4_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic [eipl4_pkg::RSP_USER_W-1:0] rsp_tuser   // [1:0] l3_kind
);

   localparam int PW = eipl4_pkg::POS_W;

   logic [PW-1:0]             pos_ff, pos_in;
   logic [47:0]               dst_mac_ff, dst_mac_in;
   logic [47:0]               src_mac_ff, src_mac_in;
   logic [15:0]               etype_ff, etype_in;
   eipl4_pkg::kind_type       kind_ff, kind_in;
   logic [PW-1:0]             l4_ff, l4_in;
   logic [7:0]                proto_ff, proto_in;
   logic [127:0]              src_addr_ff, src_addr_in;
   logic [127:0]              dst_addr_ff, dst_addr_in;
   logic [31:0]               port_ff, port_in;
   logic [7:0]                flags_ff, flags_in;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic [eipl4_pkg::RSP_DATA_W-1:0]  rsp_data_ff, rsp_data_in;
   eipl4_pkg::kind_type               rsp_kind_ff, rsp_kind_in;

   logic                 accept;
   logic                 last_accept;
   logic [7:0]           b;
   logic [PW:0]          p8, l4_8;
   logic                 is_v4, is_v6, is_ip;
   logic [7:0]           sum_proto;
   logic                 has_ports;
   eipl4_pkg::mark_type  sum_mark;

   assign req_tready  = !rsp_valid_ff || rsp_tready;
   assign accept      = req_tvalid && req_tready;
   assign last_accept = accept && req_tlast;
   assign b           = req_tdata;
   assign p8          = {1'b0, pos_ff};

   // next capture values for the byte on the input
   always_comb begin
      dst_mac_in  = dst_mac_ff;
      src_mac_in  = src_mac_ff;
      etype_in    = etype_ff;
      kind_in     = kind_ff;
      l4_in       = l4_ff;
      proto_in    = proto_ff;
      src_addr_in = src_addr_ff;
      dst_addr_in = dst_addr_ff;
      port_in     = port_ff;
      flags_in    = flags_ff;

      for (int i = 0; i < 6; i++) begin
         if (pos_ff == PW'(eipl4_pkg::DST_MAC_END - i)) begin
            dst_mac_in[8*i +: 8] = b;
         end
         if (pos_ff == PW'(eipl4_pkg::SRC_MAC_END - i)) begin
            src_mac_in[8*i +: 8] = b;
         end
      end
      if (pos_ff == eipl4_pkg::POS_ETYPE_HI) begin
         etype_in[15:8] = b;
      end
      if (pos_ff == eipl4_pkg::POS_ETYPE_LO) begin
         etype_in[7:0] = b;
      end

      if (pos_ff == eipl4_pkg::POS_IP_FIRST) begin
         kind_in = eipl4_pkg::kind_of(etype_ff, b);
         unique case (kind_in)
            eipl4_pkg::KIND_IPV4: l4_in = eipl4_pkg::ETH_HDR_LEN + {1'b0, b[3:0], 2'b00};
            eipl4_pkg::KIND_IPV6: l4_in = eipl4_pkg::IPV6_L4_START;
            default:              l4_in = '0;
         endcase
      end

      is_v4 = (kind_in == eipl4_pkg::KIND_IPV4);
      is_v6 = (kind_in == eipl4_pkg::KIND_IPV6);
      is_ip = is_v4 || is_v6;
      l4_8  = {1'b0, l4_in};

      if ((is_v4 && pos_ff == eipl4_pkg::POS_V4_PROTO)
          || (is_v6 && pos_ff == eipl4_pkg::POS_V6_NEXT)) begin
         proto_in = b;
      end

      for (int i = 0; i < 16; i++) begin
         if ((is_v6 && pos_ff == PW'(eipl4_pkg::V6_SRC_END - i))
             || (is_v4 && i < 4 && pos_ff == PW'(eipl4_pkg::V4_SRC_END - i))) begin
            src_addr_in[8*i +: 8] = b;
         end
         if ((is_v6 && pos_ff == PW'(eipl4_pkg::V6_DST_END - i))
             || (is_v4 && i < 4 && pos_ff == PW'(eipl4_pkg::V4_DST_END - i))) begin
            dst_addr_in[8*i +: 8] = b;
         end
      end

      for (int i = 0; i < 4; i++) begin
         if (is_ip && p8 == l4_8 + (PW+1)'(3 - i)) begin
            port_in[8*i +: 8] = b;
         end
      end
      if (is_ip && p8 == l4_8 + eipl4_pkg::FLAGS_OFFSET) begin
         flags_in = b;
      end

      pos_in = (pos_ff == eipl4_pkg::POS_MAX) ? pos_ff : pos_ff + PW'(1);
   end

   // summary from the values that include the last byte
   always_comb begin
      sum_proto = is_ip ? proto_in : 8'd0;
      has_ports = is_ip && (sum_proto == eipl4_pkg::PROTO_TCP
                            || sum_proto == eipl4_pkg::PROTO_UDP);
      sum_mark  = eipl4_pkg::MARK_NONE;
      if (is_ip && sum_proto == eipl4_pkg::PROTO_TCP) begin
         priority if ((flags_in & eipl4_pkg::TCP_SYN) != 8'd0) begin
            sum_mark = eipl4_pkg::MARK_SYN;
         end else if ((flags_in & eipl4_pkg::TCP_FIN) != 8'd0) begin
            sum_mark = eipl4_pkg::MARK_FIN;
         end
      end

      rsp_data_in = {
         6'd0,
         sum_mark,
         has_ports ? port_in[15:0] : 16'd0,
         has_ports ? port_in[31:16] : 16'd0,
         sum_proto,
         is_ip ? dst_addr_in[63:0] : 64'd0,
         is_v6 ? dst_addr_in[127:64] : 64'd0,
         is_ip ? src_addr_in[63:0] : 64'd0,
         is_v6 ? src_addr_in[127:64] : 64'd0,
         etype_in,
         src_mac_in,
         dst_mac_in
      };
      rsp_kind_in = kind_in;

      rsp_valid_in = rsp_valid_ff;
      if (last_accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || last_accept) begin
         pos_ff      <= '0;
         dst_mac_ff  <= '0;
         src_mac_ff  <= '0;
         etype_ff    <= '0;
         kind_ff     <= eipl4_pkg::KIND_OTHER;
         l4_ff       <= '0;
         proto_ff    <= '0;
         src_addr_ff <= '0;
         dst_addr_ff <= '0;
         port_ff     <= '0;
         flags_ff    <= '0;
      end else if (accept) begin
         pos_ff      <= pos_in;
         dst_mac_ff  <= dst_mac_in;
         src_mac_ff  <= src_mac_in;
         etype_ff    <= etype_in;
         kind_ff     <= kind_in;
         l4_ff       <= l4_in;
         proto_ff    <= proto_in;
         src_addr_ff <= src_addr_in;
         dst_addr_ff <= dst_addr_in;
         port_ff     <= port_in;
         flags_ff    <= flags_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (last_accept) begin
         rsp_data_ff <= rsp_data_in;
         rsp_kind_ff <= rsp_kind_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_kind_ff;

   `EIPL4_ASSERT(a_last_clears, last_accept |=> rsp_tvalid && pos_ff == '0 && kind_ff == eipl4_pkg::KIND_OTHER, "last item did not issue a summary and clear state")
   `EIPL4_ASSERT(a_other_no_l4, rsp_tvalid && rsp_tuser == eipl4_pkg::KIND_OTHER |-> rsp_tdata[409:368] == '0, "non-IP summary carries L4 fields")
   `EIPL4_ASSERT(a_mark_tcp, rsp_tvalid && rsp_tdata[409:408] != eipl4_pkg::MARK_NONE |-> rsp_tdata[375:368] == eipl4_pkg::PROTO_TCP, "TCP mark on non-TCP summary")
   `EIPL4_ASSERT(a_l4_range, kind_ff == eipl4_pkg::KIND_OTHER || l4_ff >= eipl4_pkg::ETH_HDR_LEN, "L4 start below Ethernet header end")
   `EIPL4_ASSERT_ALWAYS(a_reset_idle, reset |=> !rsp_tvalid, "summary valid right after reset")

endmodule

[dv/ethernet_ip_l4_header_parser_tb.sv]
// ----------------------------------------------------------------------------
// ethernet_ip_l4_header_parser_tb
// Streams Ethernet frames byte by byte into the header parser and checks
// every header summary against a position-based capture model kept here.
// A few hand-built frames come first. Random frames follow: IPv4 with normal
// and undersized IHL, IPv6, wrong version, and unknown ethertype, each of
// short, normal or over-long length. Both sides idle at random. One long
// receiver hold forces input backpressure, and some frames wait for all
// outstanding summaries before they start.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ethernet_ip_l4_header_parser_tb;

   localparam int FRAME_MAX     = 170;
   localparam int PHASE_BYTES   = 700;
   localparam int PHASE_FRAMES  = 20;
   localparam int LONG_STALL    = 400;
   localparam int SETTLE_CYCLES = 16;
   localparam int MAX_REPORTS   = 10;

   typedef struct {
      logic [7:0] data;
      logic       last;
      logic       wait_drain;
   } frame_item_type;

   typedef struct {
      logic [47:0]         dst_mac;
      logic [47:0]         src_mac;
      logic [15:0]         ether_type;
      eipl4_pkg::kind_type l3_kind;
      logic [63:0]         src_high;
      logic [63:0]         src_low;
      logic [63:0]         dst_high;
      logic [63:0]         dst_low;
      logic [7:0]          proto;
      logic [15:0]         src_port;
      logic [15:0]         dst_port;
      eipl4_pkg::mark_type tcp_mark;
   } header_summary_type;

   logic                             clock      = 1'b0;
   logic                             reset      = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [7:0]                       req_tdata  = 8'h00;  // [7:0] packet_byte
   logic                             req_tlast  = 1'b0;   // last_byte
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [eipl4_pkg::RSP_DATA_W-1:0] rsp_tdata;           // summary fields, see DUT ports
   logic [eipl4_pkg::RSP_USER_W-1:0] rsp_tuser;           // [1:0] l3_kind

   frame_item_type     frame_bytes_to_send[$];
   header_summary_type pending_summaries[$];
   header_summary_type next_summary;
   logic [7:0]         frame_buf [0:FRAME_MAX-1];

   int send_idle        = 26;
   int recv_idle        = 85;
   int stalls_requested = 0;
   int stalls_served    = 0;
   int stall_left       = 0;
   int frames_open      = 0;
   int bytes_queued     = 0;
   int summaries_seen   = 0;
   int mismatches       = 0;

   // capture state of the frame in progress
   logic [6:0]   byte_pos     = '0;
   logic [47:0]  cap_dst_mac  = '0;
   logic [47:0]  cap_src_mac  = '0;
   logic [15:0]  cap_etype    = '0;
   logic [7:0]   cap_ip_first = '0;
   int           cap_l4_start = 0;
   logic [7:0]   cap_proto    = '0;
   logic [127:0] cap_src_ip   = '0;
   logic [127:0] cap_dst_ip   = '0;
   logic [31:0]  cap_ports    = '0;
   logic [7:0]   cap_flags    = '0;

   ethernet_ip_l4_header_parser DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #4 clock = ~clock;

   function automatic eipl4_pkg::kind_type l3_class(input logic [15:0] etype,
                                                    input logic [7:0] first);
      if (etype == eipl4_pkg::ETH_IPV4 && first[7:4] == eipl4_pkg::VER_IPV4)
         return eipl4_pkg::KIND_IPV4;
      if (etype == eipl4_pkg::ETH_IPV6 && first[7:4] == eipl4_pkg::VER_IPV6)
         return eipl4_pkg::KIND_IPV6;
      return eipl4_pkg::KIND_OTHER;
   endfunction

   task automatic capture_frame_byte(input logic [7:0] b, input logic last);
      header_summary_type  s;
      eipl4_pkg::kind_type k;
      logic [7:0]          pr;
      int                  p;
      p = int'(byte_pos);
      if (p <= eipl4_pkg::DST_MAC_END) begin
         cap_dst_mac[(eipl4_pkg::DST_MAC_END - p) * 8 +: 8] = b;
      end else if (p <= eipl4_pkg::SRC_MAC_END) begin
         cap_src_mac[(eipl4_pkg::SRC_MAC_END - p) * 8 +: 8] = b;
      end else if (p == int'(eipl4_pkg::POS_ETYPE_HI)) begin
         cap_etype[15:8] = b;
      end else if (p == int'(eipl4_pkg::POS_ETYPE_LO)) begin
         cap_etype[7:0] = b;
      end else if (p == int'(eipl4_pkg::POS_IP_FIRST)) begin
         cap_ip_first = b;
         k = l3_class(cap_etype, b);
         if (k == eipl4_pkg::KIND_IPV4)
            cap_l4_start = int'(eipl4_pkg::ETH_HDR_LEN) + 4 * int'(b[3:0]);
         else if (k == eipl4_pkg::KIND_IPV6) cap_l4_start = int'(eipl4_pkg::IPV6_L4_START);
         else cap_l4_start = 0;
      end
      if (p >= int'(eipl4_pkg::POS_IP_FIRST)) begin
         k = l3_class(cap_etype, cap_ip_first);
         if (k == eipl4_pkg::KIND_IPV4) begin
            if (p == int'(eipl4_pkg::POS_V4_PROTO)) cap_proto = b;
            if (p > eipl4_pkg::V4_SRC_END - 4 && p <= eipl4_pkg::V4_SRC_END)
               cap_src_ip[(eipl4_pkg::V4_SRC_END - p) * 8 +: 8] = b;
            if (p > eipl4_pkg::V4_DST_END - 4 && p <= eipl4_pkg::V4_DST_END)
               cap_dst_ip[(eipl4_pkg::V4_DST_END - p) * 8 +: 8] = b;
         end else if (k == eipl4_pkg::KIND_IPV6) begin
            if (p == int'(eipl4_pkg::POS_V6_NEXT)) cap_proto = b;
            if (p > eipl4_pkg::V6_SRC_END - 16 && p <= eipl4_pkg::V6_SRC_END)
               cap_src_ip[(eipl4_pkg::V6_SRC_END - p) * 8 +: 8] = b;
            if (p > eipl4_pkg::V6_DST_END - 16 && p <= eipl4_pkg::V6_DST_END)
               cap_dst_ip[(eipl4_pkg::V6_DST_END - p) * 8 +: 8] = b;
         end
         if (k != eipl4_pkg::KIND_OTHER) begin
            if (p >= cap_l4_start && p < cap_l4_start + 4)
               cap_ports[(3 - (p - cap_l4_start)) * 8 +: 8] = b;
            if (p == cap_l4_start + int'(eipl4_pkg::FLAGS_OFFSET)) cap_flags = b;
         end
      end
      if (byte_pos < eipl4_pkg::POS_MAX) byte_pos = byte_pos + 7'd1;
      if (last) begin
         k  = l3_class(cap_etype, cap_ip_first);
         pr = (k == eipl4_pkg::KIND_OTHER) ? 8'h00 : cap_proto;
         s.dst_mac    = cap_dst_mac;
         s.src_mac    = cap_src_mac;
         s.ether_type = cap_etype;
         s.l3_kind    = k;
         s.src_high   = (k == eipl4_pkg::KIND_IPV6) ? cap_src_ip[127:64] : 64'd0;
         s.src_low    = (k == eipl4_pkg::KIND_OTHER) ? 64'd0 : cap_src_ip[63:0];
         s.dst_high   = (k == eipl4_pkg::KIND_IPV6) ? cap_dst_ip[127:64] : 64'd0;
         s.dst_low    = (k == eipl4_pkg::KIND_OTHER) ? 64'd0 : cap_dst_ip[63:0];
         s.proto      = pr;
         s.src_port   = 16'd0;
         s.dst_port   = 16'd0;
         s.tcp_mark   = eipl4_pkg::MARK_NONE;
         if (k != eipl4_pkg::KIND_OTHER
             && (pr == eipl4_pkg::PROTO_TCP || pr == eipl4_pkg::PROTO_UDP)) begin
            s.src_port = cap_ports[31:16];
            s.dst_port = cap_ports[15:0];
         end
         if (k != eipl4_pkg::KIND_OTHER && pr == eipl4_pkg::PROTO_TCP) begin
            if ((cap_flags & eipl4_pkg::TCP_SYN) != 8'h00) s.tcp_mark = eipl4_pkg::MARK_SYN;
            else if ((cap_flags & eipl4_pkg::TCP_FIN) != 8'h00)
               s.tcp_mark = eipl4_pkg::MARK_FIN;
         end
         pending_summaries.push_back(s);
         byte_pos     = '0;
         cap_dst_mac  = '0;
         cap_src_mac  = '0;
         cap_etype    = '0;
         cap_ip_first = '0;
         cap_l4_start = 0;
         cap_proto    = '0;
         cap_src_ip   = '0;
         cap_dst_ip   = '0;
         cap_ports    = '0;
         cap_flags    = '0;
      end
   endtask

   function automatic void check_field(input string label, input logic [63:0] want,
                                       input logic [63:0] got);
      if (got !== want) begin
         mismatches++;
         if (mismatches <= MAX_REPORTS)
            $display("summary %0d %s: expected %h, got %h", summaries_seen, label, want, got);
      end
   endfunction

   task automatic push_frame(input int len, input bit drain);
      frame_item_type it;
      for (int i = 0; i < len; i++) begin
         it.data       = frame_buf[i];
         it.last       = (i == len - 1);
         it.wait_drain = drain && (i == 0);
         frame_bytes_to_send.push_back(it);
      end
      bytes_queued += len;
   endtask

   task automatic queue_random_frame(input bit drain);
      int         len;
      int         l4;
      logic [7:0] pr;
      logic [7:0] fl;
      logic [3:0] ihl;
      logic [3:0] ver;
      for (int n = 0; n < FRAME_MAX; n++) frame_buf[n] = 8'($urandom);
      case ($urandom_range(3))
         0: pr = eipl4_pkg::PROTO_UDP;
         1: pr = 8'($urandom);
         default: pr = eipl4_pkg::PROTO_TCP;
      endcase
      fl = 8'($urandom);
      case ($urandom_range(3))
         0: fl = fl | eipl4_pkg::TCP_SYN;
         1: fl = (fl & ~eipl4_pkg::TCP_SYN) | eipl4_pkg::TCP_FIN;
         2: fl = fl & ~(eipl4_pkg::TCP_SYN | eipl4_pkg::TCP_FIN);
         default: ;
      endcase
      l4 = 0;
      case ($urandom_range(9))
         0, 1, 2, 3: begin
            // mostly legal IHL, sometimes one that lands L4 inside the IP header
            if ($urandom_range(7) == 0) ihl = 4'($urandom_range(4, 0));
            else ihl = 4'($urandom_range(15, 5));
            frame_buf[12] = eipl4_pkg::ETH_IPV4[15:8];
            frame_buf[13] = eipl4_pkg::ETH_IPV4[7:0];
            frame_buf[14] = {eipl4_pkg::VER_IPV4, ihl};
            frame_buf[23] = pr;
            l4 = int'(eipl4_pkg::ETH_HDR_LEN) + 4 * int'(ihl);
         end
         4, 5, 6, 7: begin
            frame_buf[12] = eipl4_pkg::ETH_IPV6[15:8];
            frame_buf[13] = eipl4_pkg::ETH_IPV6[7:0];
            frame_buf[14] = {eipl4_pkg::VER_IPV6, frame_buf[14][3:0]};
            frame_buf[20] = pr;
            l4 = int'(eipl4_pkg::IPV6_L4_START);
         end
         8: begin
            // known ethertype, wrong version nibble
            ver = 4'($urandom);
            if ($urandom_range(1) == 0) begin
               if (ver == eipl4_pkg::VER_IPV4) ver = ver ^ 4'd1;
               frame_buf[12] = eipl4_pkg::ETH_IPV4[15:8];
               frame_buf[13] = eipl4_pkg::ETH_IPV4[7:0];
               frame_buf[23] = pr;
            end else begin
               if (ver == eipl4_pkg::VER_IPV6) ver = ver ^ 4'd1;
               frame_buf[12] = eipl4_pkg::ETH_IPV6[15:8];
               frame_buf[13] = eipl4_pkg::ETH_IPV6[7:0];
               frame_buf[20] = pr;
            end
            frame_buf[14] = {ver, frame_buf[14][3:0]};
            l4 = 34;
         end
         default: ;
      endcase
      if (l4 != 0) frame_buf[l4 + int'(eipl4_pkg::FLAGS_OFFSET)] = fl;
      case ($urandom_range(9))
         0: len = $urandom_range(20, 1);
         1: len = $urandom_range(FRAME_MAX, 128);
         default: len = $urandom_range(100, 30);
      endcase
      push_frame(len, drain);
   endtask

   // hold off the receiver on request
   always @(posedge clock) begin
      if (stalls_served != stalls_requested) begin
         stall_left    <= LONG_STALL;
         stalls_served <= stalls_requested;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            capture_frame_byte(req_tdata, req_tlast);
            if (req_tlast) frames_open++;
            void'(frame_bytes_to_send.pop_front());
         end
         if (rsp_tvalid && rsp_tready) frames_open--;
         if (!req_tvalid || req_tready) begin
            if (frame_bytes_to_send.size() != 0
                && !(frame_bytes_to_send[0].wait_drain && frames_open != 0)
                && $urandom_range(99) >= send_idle) begin
               req_tvalid <= 1'b1;
               req_tdata  <= frame_bytes_to_send[0].data;
               req_tlast  <= frame_bytes_to_send[0].last;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            summaries_seen++;
            if (pending_summaries.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("summary %0d: none expected", summaries_seen);
            end else begin
               next_summary = pending_summaries.pop_front();
               check_field("dst_mac", 64'(next_summary.dst_mac), 64'(rsp_tdata[47:0]));
               check_field("src_mac", 64'(next_summary.src_mac), 64'(rsp_tdata[95:48]));
               check_field("ether_type", 64'(next_summary.ether_type),
                           64'(rsp_tdata[111:96]));
               check_field("l3_kind", 64'(next_summary.l3_kind), 64'(rsp_tuser));
               check_field("ip_src_high", next_summary.src_high, rsp_tdata[175:112]);
               check_field("ip_src_low", next_summary.src_low, rsp_tdata[239:176]);
               check_field("ip_dst_high", next_summary.dst_high, rsp_tdata[303:240]);
               check_field("ip_dst_low", next_summary.dst_low, rsp_tdata[367:304]);
               check_field("proto_number", 64'(next_summary.proto), 64'(rsp_tdata[375:368]));
               check_field("src_port", 64'(next_summary.src_port), 64'(rsp_tdata[391:376]));
               check_field("dst_port", 64'(next_summary.dst_port), 64'(rsp_tdata[407:392]));
               check_field("tcp_mark", 64'(next_summary.tcp_mark), 64'(rsp_tdata[409:408]));
               check_field("padding", 64'd0, 64'(rsp_tdata[415:410]));
            end
         end
         rsp_tready <= (stall_left == 0) && ($urandom_range(99) >= recv_idle);
      end
   end

   initial begin
      int frames;
      int phase_start;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // one-byte frames at both byte extremes
      frame_buf[0] = 8'h00;
      push_frame(1, 1'b0);
      frame_buf[0] = 8'hFF;
      push_frame(1, 1'b0);
      // IPv4 with IHL zero: ports overlap the IP header, SYN and FIN both set
      for (int n = 0; n < FRAME_MAX; n++) frame_buf[n] = 8'hFF;
      frame_buf[12] = eipl4_pkg::ETH_IPV4[15:8];
      frame_buf[13] = eipl4_pkg::ETH_IPV4[7:0];
      frame_buf[14] = {eipl4_pkg::VER_IPV4, 4'h0};
      frame_buf[23] = eipl4_pkg::PROTO_TCP;
      frame_buf[27] = eipl4_pkg::TCP_SYN | eipl4_pkg::TCP_FIN;
      push_frame(28, 1'b0);

      for (int phase = 0; phase < 3; phase++) begin
         if (phase > 0) begin
            wait (frame_bytes_to_send.size() == 0);
            @(negedge clock);
            if (phase == 1) begin
               send_idle = 85;
               recv_idle = 26;
            end else begin
               send_idle = 0;
               recv_idle = 0;
               stalls_requested++;
            end
         end
         frames      = 0;
         phase_start = bytes_queued;
         while (bytes_queued - phase_start < PHASE_BYTES || frames < PHASE_FRAMES) begin
            queue_random_frame(frames == 10 || $urandom_range(24) == 0);
            frames++;
         end
      end

      wait (frame_bytes_to_send.size() == 0 && pending_summaries.size() == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
